// File: rtl/gzhp_pkg.sv
// Package for the gzip member header parser: phase codes, flag masks,
// result type and the bytewise CRC-32 step. No dependencies.
`default_nettype none
package gzhp_pkg;

    localparam int COUNT_BITS = 32;

    localparam logic [7:0] ID1_BYTE      = 8'h1f;
    localparam logic [7:0] ID2_BYTE      = 8'h8b;
    localparam logic [7:0] METHOD_DEFL   = 8'h08;
    localparam logic [7:0] FL_RESERVED   = 8'he0;
    localparam logic [7:0] FL_HCRC       = 8'h02;
    localparam logic [7:0] FL_EXTRA      = 8'h04;
    localparam logic [7:0] FL_NAME       = 8'h08;
    localparam logic [7:0] FL_COMMENT    = 8'h10;
    localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
    localparam logic [31:0] HCRC_MASK    = 32'h0000FFFF;
    localparam int MIN_TOTAL             = 18;
    localparam int TRAILER_BYTES         = 8;
    localparam int FIXED_END_POS         = 9;

    typedef enum logic [3:0] {
        PH_ID1,
        PH_ID2,
        PH_METHOD,
        PH_FLAGS,
        PH_FIXED,
        PH_XLEN_LO,
        PH_XLEN_HI,
        PH_EXTRA,
        PH_NAME,
        PH_COMMENT,
        PH_HCRC_LO,
        PH_HCRC_HI,
        PH_PAYLOAD
    } phase_t;

    typedef struct packed {
        logic [31:0] stored_size;
        logic [31:0] stored_crc;
        logic [31:0] payload_length;
        logic [31:0] payload_offset;
        logic        status;
    } rslt_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // first phase at or after cand that the flags call for
    function automatic phase_t advance(input phase_t cand, input logic [7:0] flags);
        phase_t p;
        p = cand;
        if (p == PH_XLEN_LO && (flags & FL_EXTRA) == 8'd0) p = PH_NAME;
        if (p == PH_NAME && (flags & FL_NAME) == 8'd0) p = PH_COMMENT;
        if (p == PH_COMMENT && (flags & FL_COMMENT) == 8'd0) p = PH_HCRC_LO;
        if (p == PH_HCRC_LO && (flags & FL_HCRC) == 8'd0) p = PH_PAYLOAD;
        return p;
    endfunction

endpackage
`default_nettype wire

// File: rtl/gzhp_parser.sv
// Per-byte parse state, header CRC, trailer window and end-of-member result.
// Depends on gzhp_pkg.
`default_nettype none
module gzhp_parser (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic          cfg_wdata,
    input  wire logic          beat,
    input  wire logic [7:0]    data_byte,
    input  wire logic          last_byte,
    output logic               res_push,
    output gzhp_pkg::rslt_t    res
);
    import gzhp_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic                  check_hcrc_reg;
    logic [COUNT_BITS-1:0] pos_reg, pos_next;
    phase_t                phase_reg, phase_next;
    logic [7:0]            flags_reg, flags_next;
    logic [15:0]           extra_reg, extra_next;
    logic [COUNT_BITS-1:0] hlen_reg, hlen_next;
    logic                  err_reg, err_next;
    logic [31:0]           crc_reg, crc_next;
    logic [15:0]           rxcrc_reg, rxcrc_next;
    logic [7:0]            win_reg [8];
    logic [7:0]            win_next [8];

    logic [COUNT_BITS-1:0] diff;
    logic                  bad;
    logic [15:0]           xlen_full;

    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        flags_next = flags_reg;
        extra_next = extra_reg;
        hlen_next  = hlen_reg;
        err_next   = err_reg;
        crc_next   = crc_reg;
        rxcrc_next = rxcrc_reg;
        win_next   = win_reg;
        res_push   = 1'b0;
        res        = '0;
        diff       = '0;
        bad        = 1'b0;
        xlen_full  = {data_byte, extra_reg[7:0]};

        if (beat) begin
            pos_next = (pos_reg != CNT_MAX) ? pos_reg + 1'b1 : pos_reg;
            win_next[0] = data_byte;
            for (int i = 1; i < 8; i++) win_next[i] = win_reg[i-1];

            if (!err_reg) begin
                if (phase_reg < PH_HCRC_LO) crc_next = crc_byte(crc_reg, data_byte);
                case (phase_reg)
                    PH_ID1: begin
                        if (data_byte != ID1_BYTE) err_next = 1'b1;
                        else phase_next = PH_ID2;
                    end
                    PH_ID2: begin
                        if (data_byte != ID2_BYTE) err_next = 1'b1;
                        else phase_next = PH_METHOD;
                    end
                    PH_METHOD: begin
                        if (data_byte != METHOD_DEFL) err_next = 1'b1;
                        else phase_next = PH_FLAGS;
                    end
                    PH_FLAGS: begin
                        flags_next = data_byte;
                        if ((data_byte & FL_RESERVED) != 8'd0) err_next = 1'b1;
                        else phase_next = PH_FIXED;
                    end
                    PH_FIXED: begin
                        if (pos_reg >= COUNT_BITS'(FIXED_END_POS))
                            phase_next = advance(PH_XLEN_LO, flags_reg);
                    end
                    PH_XLEN_LO: begin
                        extra_next = {8'd0, data_byte};
                        phase_next = PH_XLEN_HI;
                    end
                    PH_XLEN_HI: begin
                        extra_next = xlen_full;
                        if (xlen_full == 16'd0) phase_next = advance(PH_NAME, flags_reg);
                        else phase_next = PH_EXTRA;
                    end
                    PH_EXTRA: begin
                        extra_next = extra_reg - 1'b1;
                        if (extra_next == 16'd0) phase_next = advance(PH_NAME, flags_reg);
                    end
                    PH_NAME: begin
                        if (data_byte == 8'd0) phase_next = advance(PH_COMMENT, flags_reg);
                    end
                    PH_COMMENT: begin
                        if (data_byte == 8'd0) phase_next = advance(PH_HCRC_LO, flags_reg);
                    end
                    PH_HCRC_LO: begin
                        rxcrc_next = {8'd0, data_byte};
                        phase_next = PH_HCRC_HI;
                    end
                    PH_HCRC_HI: begin
                        rxcrc_next = {data_byte, rxcrc_reg[7:0]};
                        if (check_hcrc_reg && rxcrc_next != 16'(~crc_reg & HCRC_MASK))
                            err_next = 1'b1;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                    end
                    default: begin
                        err_next = 1'b1;
                    end
                endcase
                if (phase_next == PH_PAYLOAD && phase_reg != PH_PAYLOAD)
                    hlen_next = pos_next;
            end

            if (last_byte) begin
                diff = pos_next - hlen_next;
                bad  = err_next || phase_next != PH_PAYLOAD ||
                       pos_next < COUNT_BITS'(MIN_TOTAL) || pos_next < hlen_next ||
                       diff < COUNT_BITS'(TRAILER_BYTES);
                res_push = 1'b1;
                if (bad) begin
                    res.status = 1'b1;
                end else begin
                    res.status         = 1'b0;
                    res.payload_offset = 32'(hlen_next);
                    res.payload_length = 32'(diff - COUNT_BITS'(TRAILER_BYTES));
                    res.stored_crc     = {win_next[4], win_next[5], win_next[6],
                                          win_next[7]};
                    res.stored_size    = {win_next[0], win_next[1], win_next[2],
                                          win_next[3]};
                end
                // next byte opens a new member
                pos_next   = '0;
                phase_next = PH_ID1;
                flags_next = '0;
                extra_next = '0;
                hlen_next  = '0;
                err_next   = 1'b0;
                crc_next   = CRC_INIT;
                rxcrc_next = '0;
                for (int i = 0; i < 8; i++) win_next[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_hcrc_reg <= 1'b0;
            pos_reg        <= '0;
            phase_reg      <= PH_ID1;
            flags_reg      <= '0;
            extra_reg      <= '0;
            hlen_reg       <= '0;
            err_reg        <= 1'b0;
            crc_reg        <= CRC_INIT;
            rxcrc_reg      <= '0;
            for (int i = 0; i < 8; i++) win_reg[i] <= '0;
        end else begin
            if (cfg_we) check_hcrc_reg <= cfg_wdata;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            extra_reg <= extra_next;
            hlen_reg  <= hlen_next;
            err_reg   <= err_next;
            crc_reg   <= crc_next;
            rxcrc_reg <= rxcrc_next;
            win_reg   <= win_next;
        end
    end

    a_member_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        beat && last_byte |=> pos_reg == '0 && phase_reg == PH_ID1 && !err_reg)
        else $error("member state not cleared after final byte");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg && !(beat && last_byte) |=> err_reg)
        else $error("format error dropped inside a member");

    a_hlen_min: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> hlen_reg >= COUNT_BITS'(FIXED_END_POS + 1))
        else $error("payload phase with short header length");

endmodule
`default_nettype wire

// File: rtl/gzhp_out_buf.sv
// Two-entry result buffer (output register plus skid) for the result channel.
// Depends on gzhp_pkg.
`default_nettype none
module gzhp_out_buf (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  gzhp_pkg::rslt_t    push_data,
    output logic               room,
    output logic               out_valid,
    input  wire logic          out_ready,
    output gzhp_pkg::rslt_t    out_data
);
    import gzhp_pkg::*;

    logic  o_valid_reg, k_valid_reg;
    rslt_t o_reg, k_reg;
    logic  take;

    assign take      = o_valid_reg && out_ready;
    assign room      = !k_valid_reg;
    assign out_valid = o_valid_reg;
    assign out_data  = o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
        end else if (k_valid_reg) begin
            if (take) begin
                o_reg       <= k_reg;
                k_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!o_valid_reg || take) begin
                o_reg       <= push_data;
                o_valid_reg <= 1'b1;
            end else begin
                k_reg       <= push_data;
                k_valid_reg <= 1'b1;
            end
        end else if (take) begin
            o_valid_reg <= 1'b0;
        end
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        k_valid_reg |-> o_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> room)
        else $error("result pushed into full buffer");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        push && o_valid_reg && !out_ready |=> k_valid_reg && o_valid_reg)
        else $error("stalled result not parked in skid");

endmodule
`default_nettype wire

// File: rtl/gzip_member_header_parser.sv
// Top level of the gzip member header/trailer parser: stream ports, parser
// core and result buffer. Depends on gzhp_pkg, gzhp_parser, gzhp_out_buf.
//
//  channel  | ports                         | payload
//  ---------+-------------------------------+------------------------------------
//  input    | s_tvalid s_tready s_tdata/last| data_byte, last_byte
//  result   | m_tvalid m_tready m_tdata/user| offset, length, crc, size; status
//  config   | cfg_we cfg_wdata              | check_header_crc
//
//  One byte per cycle while s_tready is high; each beat updates the parse state
//  in the cycle it is taken. A final-byte beat pushes its result into the result buffer.
//  The result buffer holds two results; s_tready drops only while both are full.
//  aresetn is synchronous, active low, and clears all member state and the register.
`default_nettype none
module gzip_member_header_parser (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // [31:0] offset, [63:32] length,
                                         // [95:64] stored_crc, [127:96] stored_size
    output logic              m_tuser    // [0] status
);
    import gzhp_pkg::*;

    logic  beat;
    logic  res_push;
    rslt_t res;
    rslt_t out_res;

    assign beat = s_tvalid && s_tready;

    gzhp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .beat      (beat),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .res_push  (res_push),
        .res       (res)
    );

    gzhp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.stored_size, out_res.stored_crc,
                      out_res.payload_length, out_res.payload_offset};
    assign m_tuser = out_res.status;

endmodule
`default_nettype wire

// File: tb/sv/tb_gzip_member_header_parser.sv
// Self-checking testbench for gzip_member_header_parser: gzip members (good and broken)
// go in on the s_ stream and the m_ results are checked against a cycle-free predictor.
// Depends on gzhp_pkg and the parser RTL only.
`timescale 1ns / 100ps

module tb_gzip_member_header_parser;
    import gzhp_pkg::*;

    localparam logic [31:0] POS_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    typedef enum int {
        MK_GOOD, MK_BAD_ID1, MK_BAD_ID2, MK_BAD_METHOD, MK_RESERVED,
        MK_TRUNC_HDR, MK_SHORT_TAIL, MK_NOISE
    } member_kind_t;

    typedef enum int { RX_OPEN, RX_HALF, RX_SLOW, RX_MOSTLY } rx_mode_t;

    // predictor of the parser plus the queue of expected results
    class gzhp_scoreboard;
        bit          check_hcrc;
        logic [31:0] pos;
        phase_t      phase;
        logic [7:0]  flags;
        logic [15:0] extra_left;
        logic [31:0] hdr_len;
        bit          err;
        logic [31:0] crc;
        logic [15:0] rx_hcrc;
        logic [7:0]  window [8];
        rslt_t       expected_q[$];
        int          n_mismatch;
        int          n_clean;
        int          n_flagged;
        int          n_checked;

        function new();
            check_hcrc = 1'b0;
            n_mismatch = 0;
            n_clean = 0;
            n_flagged = 0;
            n_checked = 0;
            restart_member();
        endfunction

        static function logic [31:0] crc32_update(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            int k;
            r = c ^ {24'd0, b};
            for (k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            return r;
        endfunction

        function void restart_member();
            int k;
            pos = '0;
            phase = PH_ID1;
            flags = '0;
            extra_left = '0;
            hdr_len = '0;
            err = 1'b0;
            crc = CRC_INIT;
            rx_hcrc = '0;
            for (k = 0; k < 8; k++) window[k] = '0;
        endfunction

        // skip the optional fields that the flags leave out
        function void enter_field(phase_t cand, logic [31:0] nxt);
            phase_t p;
            p = cand;
            if (p == PH_XLEN_LO && !flags[2]) p = PH_NAME;
            if (p == PH_NAME && !flags[3]) p = PH_COMMENT;
            if (p == PH_COMMENT && !flags[4]) p = PH_HCRC_LO;
            if (p == PH_HCRC_LO && !flags[1]) p = PH_PAYLOAD;
            if (p == PH_PAYLOAD) hdr_len = nxt;
            phase = p;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic [31:0] cur;
            logic [31:0] nxt;
            logic [31:0] total;
            rslt_t r;
            int k;
            cur = pos;
            nxt = (pos != POS_MAX) ? pos + 32'd1 : pos;
            pos = nxt;
            for (k = 7; k > 0; k--) window[k] = window[k-1];
            window[0] = b;

            if (!err) begin
                if (phase < PH_HCRC_LO) crc = crc32_update(crc, b);
                case (phase)
                    PH_ID1: begin
                        if (b != ID1_BYTE) err = 1'b1; else phase = PH_ID2;
                    end
                    PH_ID2: begin
                        if (b != ID2_BYTE) err = 1'b1; else phase = PH_METHOD;
                    end
                    PH_METHOD: begin
                        if (b != METHOD_DEFL) err = 1'b1; else phase = PH_FLAGS;
                    end
                    PH_FLAGS: begin
                        flags = b;
                        if ((b & FL_RESERVED) != 8'd0) err = 1'b1; else phase = PH_FIXED;
                    end
                    PH_FIXED: begin
                        if (cur >= FIXED_END_POS) enter_field(PH_XLEN_LO, nxt);
                    end
                    PH_XLEN_LO: begin
                        extra_left = {8'd0, b};
                        phase = PH_XLEN_HI;
                    end
                    PH_XLEN_HI: begin
                        extra_left[15:8] = b;
                        if (extra_left == 16'd0) enter_field(PH_NAME, nxt);
                        else phase = PH_EXTRA;
                    end
                    PH_EXTRA: begin
                        extra_left = extra_left - 16'd1;
                        if (extra_left == 16'd0) enter_field(PH_NAME, nxt);
                    end
                    PH_NAME: begin
                        if (b == 8'd0) enter_field(PH_COMMENT, nxt);
                    end
                    PH_COMMENT: begin
                        if (b == 8'd0) enter_field(PH_HCRC_LO, nxt);
                    end
                    PH_HCRC_LO: begin
                        rx_hcrc = {8'd0, b};
                        phase = PH_HCRC_HI;
                    end
                    PH_HCRC_HI: begin
                        rx_hcrc[15:8] = b;
                        if (check_hcrc && {16'd0, rx_hcrc} != ((~crc) & HCRC_MASK))
                            err = 1'b1;
                        else enter_field(PH_PAYLOAD, nxt);
                    end
                    PH_PAYLOAD: ;
                    default: err = 1'b1;
                endcase
            end

            if (last) begin
                total = pos;
                r = '0;
                if (err || phase != PH_PAYLOAD || total < MIN_TOTAL || total < hdr_len ||
                    total - hdr_len < TRAILER_BYTES) begin
                    r.status = 1'b1;
                    n_flagged++;
                end else begin
                    r.payload_offset = hdr_len;
                    r.payload_length = total - hdr_len - TRAILER_BYTES;
                    r.stored_crc = {window[4], window[5], window[6], window[7]};
                    r.stored_size = {window[0], window[1], window[2], window[3]};
                    n_clean++;
                end
                expected_q.push_back(r);
                restart_member();
            end
        endfunction

        function void check_result(logic [127:0] tdata, logic tuser);
            rslt_t want;
            rslt_t got;
            got = rslt_t'({tdata, tuser});
            n_checked++;
            if (expected_q.size() == 0) begin
                if (n_mismatch < 10)
                    $display("unexpected result: status %0d tdata %h", tuser, tdata);
                n_mismatch++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status ||
                got.payload_offset !== want.payload_offset ||
                got.payload_length !== want.payload_length ||
                got.stored_crc !== want.stored_crc ||
                got.stored_size !== want.stored_size) begin
                if (n_mismatch < 10) begin
                    $display("mismatch, result %0d: exp status %0d off %0d len %0d %s",
                             n_checked, want.status, want.payload_offset,
                             want.payload_length,
                             $sformatf("crc %h size %h", want.stored_crc,
                                       want.stored_size));
                    $display("                      got status %0d off %0d len %0d %s",
                             got.status, got.payload_offset, got.payload_length,
                             $sformatf("crc %h size %h", got.stored_crc,
                                       got.stored_size));
                end
                n_mismatch++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_wdata = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'd0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;

    gzhp_scoreboard sb = new();
    logic [7:0]     member_bytes[$];
    int             burst_left = 0;
    int             bytes_sent = 0;
    int             members_sent = 0;
    int             stall_cycles = 0;
    bit             saw_hcrc_fail_path = 1'b0;

    gzip_member_header_parser DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("tb_gzip_member_header_parser failed");
        $finish;
    end

    // result side: ready pattern in modes, plus long hold-offs to back up the parser
    initial begin : rx_pattern
        int       cyc;
        int       mode_left;
        int       hold_left;
        rx_mode_t mode;
        cyc = 0;
        mode_left = 0;
        hold_left = 0;
        mode = RX_OPEN;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc == 600 || cyc == 2400) hold_left = 400;
            if (mode_left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(10, 120);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SLOW:   m_tready <= ($urandom_range(0, 4) == 0);
                    RX_MOSTLY: m_tready <= ($urandom_range(0, 6) != 0);
                    default:   m_tready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
        if (aresetn && s_tvalid && !s_tready) stall_cycles++;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(b, last);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_member();
        int i;
        for (i = 0; i < member_bytes.size(); i++)
            send_byte(member_bytes[i], i == member_bytes.size() - 1);
        members_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.check_hcrc = v;
        cfg_we <= 1'b0;
    endtask

    function automatic void make_member(input member_kind_t kind);
        logic [7:0]  flg;
        logic [31:0] c;
        int          xlen;
        int          pay;
        int          hlen;
        int          n;
        flg = 8'($urandom_range(0, 31));
        member_bytes = '{ID1_BYTE, ID2_BYTE, METHOD_DEFL, flg};
        repeat (6) member_bytes.push_back(8'($urandom));
        if ((flg & FL_EXTRA) != 8'd0) begin
            xlen = ($urandom_range(0, 39) == 0) ? $urandom_range(256, 300)
                                                : $urandom_range(0, 6);
            member_bytes.push_back(xlen[7:0]);
            member_bytes.push_back(xlen[15:8]);
            repeat (xlen) member_bytes.push_back(8'($urandom));
        end
        if ((flg & FL_NAME) != 8'd0) begin
            repeat ($urandom_range(0, 5)) member_bytes.push_back(8'($urandom_range(1, 255)));
            member_bytes.push_back(8'd0);
        end
        if ((flg & FL_COMMENT) != 8'd0) begin
            repeat ($urandom_range(0, 5)) member_bytes.push_back(8'($urandom_range(1, 255)));
            member_bytes.push_back(8'd0);
        end
        if ((flg & FL_HCRC) != 8'd0) begin
            c = CRC_INIT;
            foreach (member_bytes[i]) c = gzhp_scoreboard::crc32_update(c, member_bytes[i]);
            c = ~c;
            if ($urandom_range(0, 4) == 0) begin
                c[15:0] = c[15:0] ^ 16'($urandom_range(1, 65535));
                saw_hcrc_fail_path = 1'b1;
            end
            member_bytes.push_back(c[7:0]);
            member_bytes.push_back(c[15:8]);
        end
        hlen = member_bytes.size();
        pay = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
        repeat (pay + TRAILER_BYTES) member_bytes.push_back(8'($urandom));

        case (kind)
            MK_BAD_ID1:    member_bytes[0] = member_bytes[0] ^ 8'($urandom_range(1, 255));
            MK_BAD_ID2:    member_bytes[1] = member_bytes[1] ^ 8'($urandom_range(1, 255));
            MK_BAD_METHOD: member_bytes[2] = member_bytes[2] ^ 8'($urandom_range(1, 255));
            MK_RESERVED:   member_bytes[3] = member_bytes[3] | 8'(1 << $urandom_range(5, 7));
            MK_TRUNC_HDR: begin
                n = $urandom_range(1, hlen);
                member_bytes = member_bytes[0:n-1];
            end
            MK_SHORT_TAIL: begin
                n = hlen + $urandom_range(0, TRAILER_BYTES - 1);
                member_bytes = member_bytes[0:n-1];
            end
            MK_NOISE: begin
                member_bytes.delete();
                repeat ($urandom_range(1, 12)) member_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
    endfunction

    initial begin : stimulus
        bit           cfg_plan[6];
        int           ph;
        int           r;
        member_kind_t kind;
        cfg_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_cfg(1'b1);

        // shortest legal member, FTEXT set, extreme byte values
        member_bytes = '{ID1_BYTE, ID2_BYTE, METHOD_DEFL, 8'h01,
                         8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff,
                         8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff};
        send_member();
        // lone byte: wrong ID and far too short
        member_bytes = '{8'h00};
        send_member();
        // wrong method
        member_bytes = '{ID1_BYTE, ID2_BYTE, 8'h07};
        send_member();

        for (ph = 0; ph < 6; ph++) begin
            wait_idle();
            write_cfg(cfg_plan[ph]);
            while (bytes_sent < 22 + (ph + 1) * 192) begin
                r = $urandom_range(0, 99);
                if (r < 62) kind = MK_GOOD;
                else kind = member_kind_t'(1 + (r % 7));
                make_member(kind);
                send_member();
            end
        end
        wait_idle();

        $display("%0d bytes in %0d members; %0d clean results, %0d flagged; %s",
                 bytes_sent, members_sent, sb.n_clean, sb.n_flagged,
                 "hcrc check on and off");
        $display("corrupted header CRC sent: %0d; input stalled %0d cycles by backpressure",
                 saw_hcrc_fail_path, stall_cycles);
        if (sb.pending() != 0) $display("%0d expected results never arrived", sb.pending());
        if (sb.n_mismatch == 0 && sb.pending() == 0)
            $display("tb_gzip_member_header_parser passed");
        else
            $display("tb_gzip_member_header_parser failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/gzhp_pkg.sv
rtl/gzhp_parser.sv
rtl/gzhp_out_buf.sv
rtl/gzip_member_header_parser.sv
tb/sv/tb_gzip_member_header_parser.sv
